[rtl/pqem_pkg.sv]
package pqem_pkg;

  // field widths of the request and result items
  localparam int REQ_W         = 2;
  localparam int VALUE_W       = 32;
  localparam int PRI_W         = 16;
  localparam int ENTRY_COUNT_W = 5;

  // request codes
  localparam logic [REQ_W-1:0] REQ_INSERT  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_EXTRACT = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR   = 2'd2;

  // value returned by an extract on an empty queue
  localparam logic signed [VALUE_W-1:0] EMPTY_VALUE = -32'sd1;

  // one stored queue entry
  typedef struct packed {
    logic [PRI_W-1:0]          pri;
    logic signed [VALUE_W-1:0] value;
  } entry_t;

endpackage

[rtl/pqem_ifs.sv]
// request channel
interface pqem_req_if;
  import pqem_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [REQ_W-1:0]          req_type;
  logic signed [VALUE_W-1:0] item_value;
  logic [PRI_W-1:0]          item_priority;

  modport source (output valid, output req_type, output item_value,
                  output item_priority, input ready);
  modport sink   (input valid, input req_type, input item_value,
                  input item_priority, output ready);
endinterface

// result channel
interface pqem_rsp_if;
  import pqem_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] out_value;
  logic                      extract_empty;
  logic                      insert_dropped;
  logic [ENTRY_COUNT_W-1:0]  entry_count;
  logic                      queue_full;
  logic                      queue_empty;

  modport source (output valid, output out_value, output extract_empty,
                  output insert_dropped, output entry_count, output queue_full,
                  output queue_empty, input ready);
  modport sink   (input valid, input out_value, input extract_empty,
                  input insert_dropped, input entry_count, input queue_full,
                  input queue_empty, output ready);
endinterface

[rtl/pqem_store.sv]
module pqem_store #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  pqem_pkg::entry_t wdata,
  input  logic [AW-1:0]    raddr,
  output pqem_pkg::entry_t rdata
);
  import pqem_pkg::*;

  entry_t mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/priority_queue_extract_max.sv]
// Bounded priority queue of QUEUE_DEPTH (value, priority) entries kept unsorted in
// arrival order in a single-port-read entry memory. Insert, clear and unused request
// codes go from acceptance straight to the finish state. An extract of a queue holding n
// entries reads one priority per cycle from the entry memory to find the first
// entry with the greatest priority (at position b), then moves the n-1-b later
// entries down one place, one per cycle through the same read and write ports;
// none moves when the winner is the last entry. An extract on an empty queue also
// goes straight to the finish state. One item is worked on at a time; req.ready is high
// only while no item is in progress, and a result waits in the output register
// until it is taken. Every request gives exactly one result.
module priority_queue_extract_max #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic     clk,
  input  logic     rst,
  pqem_req_if.sink   req,
  pqem_rsp_if.source rsp
);
  import pqem_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_SCAN     = 3'd1;
  localparam logic [2:0] ST_SHIFT_RD = 3'd2;
  localparam logic [2:0] ST_SHIFT    = 3'd3;
  localparam logic [2:0] ST_FINISH   = 3'd4;

  logic [2:0]                state;
  logic [CW-1:0]             count;
  logic [AW-1:0]             idx;
  logic [AW-1:0]             best_idx;
  logic [PRI_W-1:0]          best_pri;
  logic signed [VALUE_W-1:0] res_value;
  logic                      res_empty;
  logic                      res_dropped;

  logic                      out_valid;
  logic signed [VALUE_W-1:0] out_value;
  logic                      out_empty;
  logic                      out_dropped;
  logic [ENTRY_COUNT_W-1:0]  out_count;
  logic                      out_full;
  logic                      out_qempty;

  logic                      mem_we;
  logic [AW-1:0]             mem_waddr;
  entry_t                    mem_wdata;
  logic [AW-1:0]             mem_raddr;
  entry_t                    mem_rdata;

  logic                      in_acc;
  logic                      out_free;
  logic                      not_full;
  logic                      take;
  logic [AW-1:0]             best_idx_next;
  logic                      scan_last;
  logic                      shift_last;
  logic [CW+ENTRY_COUNT_W-1:0] count_ext;

  // entry memory
  pqem_store #(
    .DEPTH (QUEUE_DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // handshake
  assign req.ready = (state == ST_IDLE);
  assign in_acc    = req.valid && req.ready;
  assign out_free  = !out_valid || rsp.ready;
  assign not_full  = (count < CW'(QUEUE_DEPTH));

  // scan compare unit: keep the first of equal maxima
  assign take          = (idx == '0) || (mem_rdata.pri > best_pri);
  assign best_idx_next = take ? idx : best_idx;
  assign scan_last     = ((CW'(idx) + CW'(1)) == count);
  assign shift_last    = ((CW'(idx) + CW'(1)) == count);

  // memory address and write selection
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = count[AW-1:0];
    mem_wdata = '{pri: req.item_priority, value: req.item_value};
    mem_raddr = '0;
    unique case (state)
      ST_IDLE: begin
        mem_we = in_acc && (req.req_type == REQ_INSERT) && not_full;
      end
      ST_SCAN, ST_SHIFT_RD: begin
        mem_raddr = idx + AW'(1);
      end
      ST_SHIFT: begin
        mem_we    = 1'b1;
        mem_waddr = idx;
        mem_wdata = mem_rdata;
        mem_raddr = idx + AW'(2);
      end
      default: begin
        mem_raddr = '0;
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      // a finishing item reloads the result register instead
      if (out_valid && rsp.ready && (state != ST_FINISH)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_acc) begin
            res_value   <= '0;
            res_empty   <= 1'b0;
            res_dropped <= 1'b0;
            idx         <= '0;
            state       <= ST_FINISH;
            unique case (req.req_type)
              REQ_INSERT: begin
                if (not_full) begin
                  count <= count + CW'(1);
                end else begin
                  res_dropped <= 1'b1;
                end
              end
              REQ_EXTRACT: begin
                if (count == '0) begin
                  res_value <= EMPTY_VALUE;
                  res_empty <= 1'b1;
                end else begin
                  state <= ST_SCAN;
                end
              end
              REQ_CLEAR: begin
                count <= '0;
              end
              default: begin
                count <= count;
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (take) begin
            best_pri  <= mem_rdata.pri;
            best_idx  <= idx;
            res_value <= mem_rdata.value;
          end
          if (scan_last) begin
            count <= count - CW'(1);
            if ((CW'(best_idx_next) + CW'(1)) == count) begin
              state <= ST_FINISH;
            end else begin
              idx   <= best_idx_next;
              state <= ST_SHIFT_RD;
            end
          end else begin
            idx <= idx + AW'(1);
          end
        end
        ST_SHIFT_RD: begin
          state <= ST_SHIFT;
        end
        ST_SHIFT: begin
          idx <= idx + AW'(1);
          if (shift_last) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // result register
  assign count_ext = {{ENTRY_COUNT_W{1'b0}}, count};

  always_ff @(posedge clk) begin
    if ((state == ST_FINISH) && out_free) begin
      out_value   <= res_value;
      out_empty   <= res_empty;
      out_dropped <= res_dropped;
      out_count   <= count_ext[ENTRY_COUNT_W-1:0];
      out_full    <= (count == CW'(QUEUE_DEPTH));
      out_qempty  <= (count == '0);
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.out_value      = out_value;
  assign rsp.extract_empty  = out_empty;
  assign rsp.insert_dropped = out_dropped;
  assign rsp.entry_count    = out_count;
  assign rsp.queue_full     = out_full;
  assign rsp.queue_empty    = out_qempty;

`ifndef SYNTHESIS
  // held count stays within capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(QUEUE_DEPTH))
    else $error("held count exceeds capacity");

  // shift destination stays below the held count
  a_shift_dest: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SHIFT) |-> (CW'(idx) < count))
    else $error("shift destination out of range");

  // an empty extract reports an empty queue and the empty value
  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_empty) |-> (out_qempty && (out_value == EMPTY_VALUE)))
    else $error("empty extract result inconsistent");

  // a finished result leaves the sequencer idle
  a_finish_idle: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_FINISH) && out_free) |=> (out_valid && (state == ST_IDLE)))
    else $error("result not loaded at finish");
`endif

endmodule

[sim/tb_priority_queue_extract_max.sv]
`timescale 1ns / 1ps

module tb_priority_queue_extract_max;
  import pqem_pkg::*;

  localparam int DEPTH       = 16;
  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_AT     = 1400;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_WAIT  = 60;

  // request code that the block leaves without effect
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  typedef struct packed {
    logic [REQ_W-1:0]          kind;
    logic signed [VALUE_W-1:0] value;
    logic [PRI_W-1:0]          pri;
  } request_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] out_value;
    logic                      extract_empty;
    logic                      insert_dropped;
    logic [ENTRY_COUNT_W-1:0]  entry_count;
    logic                      queue_full;
    logic                      queue_empty;
  } outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  pqem_req_if req_ch ();
  pqem_rsp_if rsp_ch ();

  priority_queue_extract_max #(
    .QUEUE_DEPTH(DEPTH)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow copy of the queue contents
  logic signed [VALUE_W-1:0] shadow_value [DEPTH];
  logic [PRI_W-1:0]          shadow_pri [DEPTH];
  int                        shadow_count = 0;

  request_t req_backlog [$];
  outcome_t predicted_outcomes [$];

  int  src_idle_pct = 0;
  int  snk_idle_pct = 0;
  int  mismatches = 0;
  int  results_seen = 0;
  int  quiet_cycles = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  bit  req_taken = 1'b0;

  // apply one request to the shadow queue and return its outcome
  function automatic outcome_t serve_request(request_t r);
    outcome_t res;
    int       best;
    logic [PRI_W-1:0] best_pri;
    res = '0;
    case (r.kind)
      REQ_INSERT: begin
        if (shadow_count < DEPTH) begin
          shadow_value[shadow_count] = r.value;
          shadow_pri[shadow_count] = r.pri;
          shadow_count++;
        end else begin
          res.insert_dropped = 1'b1;
        end
      end
      REQ_EXTRACT: begin
        if (shadow_count == 0) begin
          res.extract_empty = 1'b1;
          res.out_value = EMPTY_VALUE;
        end else begin
          // earliest entry among equal maxima wins
          best = 0;
          best_pri = shadow_pri[0];
          for (int k = 1; k < shadow_count; k++) begin
            if (shadow_pri[k] > best_pri) begin
              best_pri = shadow_pri[k];
              best = k;
            end
          end
          res.out_value = shadow_value[best];
          for (int k = best; k + 1 < shadow_count; k++) begin
            shadow_value[k] = shadow_value[k + 1];
            shadow_pri[k] = shadow_pri[k + 1];
          end
          shadow_count--;
        end
      end
      REQ_CLEAR: begin
        shadow_count = 0;
      end
      default: begin
      end
    endcase
    res.entry_count = shadow_count[ENTRY_COUNT_W-1:0];
    res.queue_full = (shadow_count == DEPTH);
    res.queue_empty = (shadow_count == 0);
    return res;
  endfunction

  task automatic push_req(logic [REQ_W-1:0] kind, logic signed [VALUE_W-1:0] value,
                          logic [PRI_W-1:0] pri);
    request_t r;
    r.kind = kind;
    r.value = value;
    r.pri = pri;
    req_backlog.push_back(r);
  endtask

  // bursts that lean toward filling, draining or mixing the queue
  task automatic push_random_reqs(int n);
    int count;
    int mode;
    int burst;
    int roll;
    int insert_pct;
    bit narrow;
    logic [REQ_W-1:0] kind;
    logic [PRI_W-1:0] pri;
    count = 0;
    while (count < n) begin
      mode = $urandom_range(2);
      burst = $urandom_range(40, 8);
      narrow = 1'($urandom_range(1));
      insert_pct = (mode == 0) ? 80 : (mode == 1) ? 20 : 50;
      for (int j = 0; j < burst && count < n; j++) begin
        roll = $urandom_range(99);
        if (roll < 2)
          kind = REQ_CLEAR;
        else if (roll < 4)
          kind = REQ_UNUSED;
        else if ($urandom_range(99) < insert_pct)
          kind = REQ_INSERT;
        else
          kind = REQ_EXTRACT;
        if (narrow)
          pri = PRI_W'($urandom_range(3));
        else if ($urandom_range(9) == 0)
          pri = $urandom_range(1) ? {PRI_W{1'b1}} : '0;
        else
          pri = PRI_W'($urandom_range(16'hFFFF));
        push_req(kind, $urandom, pri);
        if (kind != REQ_UNUSED)
          count++;
      end
    end
  endtask

  // sample both channels at the rising edge
  always @(posedge clk) begin : watch_ports
    outcome_t want;
    outcome_t got;
    req_taken = !rst && req_ch.valid && req_ch.ready;
    if (req_taken)
      predicted_outcomes.push_back(serve_request({req_ch.req_type, req_ch.item_value,
                                                  req_ch.item_priority}));
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got = {rsp_ch.out_value, rsp_ch.extract_empty, rsp_ch.insert_dropped,
             rsp_ch.entry_count, rsp_ch.queue_full, rsp_ch.queue_empty};
      if (predicted_outcomes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: value %0d count %0d", got.out_value, got.entry_count);
      end else begin
        want = predicted_outcomes.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"result %0d (expected/actual): value %0d/%0d empty %b/%b ",
                      "dropped %b/%b count %0d/%0d full %b/%b qempty %b/%b"},
                     results_seen, want.out_value, got.out_value,
                     want.extract_empty, got.extract_empty,
                     want.insert_dropped, got.insert_dropped,
                     want.entry_count, got.entry_count,
                     want.queue_full, got.queue_full,
                     want.queue_empty, got.queue_empty);
        end
      end
      results_seen++;
    end
  end

  // request driver, fed from the backlog
  always @(negedge clk) begin : drive_requests
    request_t nxt;
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_taken) begin
      if (req_backlog.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        nxt = req_backlog.pop_front();
        req_ch.valid <= 1'b1;
        req_ch.req_type <= nxt.kind;
        req_ch.item_value <= nxt.value;
        req_ch.item_priority <= nxt.pri;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // result receiver with random stalls and one long hold
  always @(negedge clk) begin
    if (hold_left != 0) begin
      rsp_ch.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && results_seen >= HOLD_AT) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // watchdog on cycles without any accepted item
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    req_ch.valid = 1'b0;
    req_ch.req_type = REQ_INSERT;
    req_ch.item_value = '0;
    req_ch.item_priority = '0;
    rsp_ch.ready = 1'b0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // phase one: sender idles lightly, receiver heavily
    src_idle_pct = 23;
    snk_idle_pct = 48;

    // empty queue, unused code and clear with nothing held
    push_req(REQ_EXTRACT, 32'sh1234_5678, 16'hABCD);
    push_req(REQ_UNUSED, 32'sh7FFF_FFFF, 16'hFFFF);
    push_req(REQ_CLEAR, 32'sh8000_0000, 16'h0000);
    // fill to capacity with extreme values and tied priorities
    push_req(REQ_INSERT, 32'sh8000_0000, 16'h0000);
    push_req(REQ_INSERT, 32'sh7FFF_FFFF, 16'hFFFF);
    push_req(REQ_INSERT, -32'sd1, 16'hFFFF);
    push_req(REQ_INSERT, 32'sd0, 16'h0000);
    for (int k = 4; k < DEPTH; k++)
      push_req(REQ_INSERT, k * 32'sh1111_1111, (k % 3 == 0) ? 16'hFFFF : 16'(k));
    // full queue: dropped insert and unused code
    push_req(REQ_INSERT, 32'sd12345, 16'hFFFF);
    push_req(REQ_UNUSED, 32'sd0, 16'h0000);
    // ties at the top resolve to the earliest entry
    push_req(REQ_EXTRACT, 32'sh5555_5555, 16'h5555);
    push_req(REQ_EXTRACT, 32'shAAAA_AAAA, 16'hAAAA);
    push_req(REQ_CLEAR, 32'sd0, 16'h0000);
    push_req(REQ_EXTRACT, 32'sd0, 16'h0000);

    push_random_reqs(625);
    while (req_backlog.size() != 0) @(negedge clk);

    // phase two: roles of the two sides swapped
    src_idle_pct = 48;
    snk_idle_pct = 23;
    push_random_reqs(625);
    while (req_backlog.size() != 0) @(negedge clk);

    // phase three: no idling
    src_idle_pct = 0;
    snk_idle_pct = 0;
    push_random_reqs(625);

    while (req_backlog.size() != 0 || req_ch.valid || predicted_outcomes.size() != 0)
      @(negedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (mismatches == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
